// ===== sv/led_fade_program_sequencer_core_assert.svh =====
// Assertion macros shared by the LED fade sequencer modules.
`ifndef LED_FADE_PROGRAM_SEQUENCER_CORE_ASSERT_SVH
`define LED_FADE_PROGRAM_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LFPS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfps: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LFPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfps: next-cycle check failed");

`endif

// ===== sv/lfps_pkg.sv =====
// Shared types, constants and program decode functions of the LED fade sequencer.
package lfps_pkg;

   localparam int LED_COUNT     = 64;
   localparam int LED_IDX_W     = 6;
   localparam int PROGRAM_STEPS = 16;
   localparam int STEP_W        = 4;
   localparam int PAIR_COUNT    = 8;
   localparam int PAIR_IDX_W    = 3;
   localparam int CSR_IDX_W     = 4;
   localparam int PAIR_W        = 20;
   localparam int CODE_W        = 10;
   localparam int LEN_W         = 8;
   localparam int KIND_W        = 2;
   localparam int LEVEL_W       = 8;
   localparam int NUM_W         = 16;
   localparam int REM_W         = 9;
   localparam int DIV_CNT_W     = 4;

   localparam logic [KIND_W-1:0] KIND_WAIT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OUT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_HOLD = 2'd3;

   localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(PROGRAM_STEPS - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(NUM_W - 1);

   typedef logic [PAIR_COUNT-1:0][PAIR_W-1:0] pairs_type;

   // Pair 7 first: packed arrays list the highest index on the left.
   localparam pairs_type PAIR_RESET = {
      20'd51742, 20'd51459, 20'd1539, 20'd102661,
      20'd1541,  20'd102663, 20'd1543, 20'd51556
   };

   typedef struct packed {
      logic [LEN_W-1:0]   frame;
      logic [STEP_W-1:0]  step;
      logic               done;
      logic [LEVEL_W-1:0] level;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic idle;
      logic accept;
      logic eval;
      logic div_step;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic [CODE_W-1:0] step_code(input pairs_type pairs,
                                                   input logic [STEP_W-1:0] step);
      logic [PAIR_W-1:0] word;
      word = pairs[step[STEP_W-1:1]];
      return step[0] ? word[2*CODE_W-1:CODE_W] : word[CODE_W-1:0];
   endfunction

   function automatic logic [KIND_W-1:0] step_kind(input pairs_type pairs,
                                                   input logic [STEP_W-1:0] step);
      logic [CODE_W-1:0] code;
      code = step_code(pairs, step);
      return code[CODE_W-1:LEN_W];
   endfunction

   // A zero length counts as one frame.
   function automatic logic [LEN_W-1:0] step_len(input pairs_type pairs,
                                                 input logic [STEP_W-1:0] step);
      logic [CODE_W-1:0] code;
      code = step_code(pairs, step);
      return (code[LEN_W-1:0] == '0) ? LEN_W'(1) : code[LEN_W-1:0];
   endfunction

endpackage

// ===== sv/lfps_datapath.sv =====
// Datapath: program registers, per-LED state memory, serial divider, result register.
`include "led_fade_program_sequencer_core_assert.svh"

module lfps_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfps_pkg::cmd_type                    cmd,
   output lfps_pkg::status_type                 status,
   input  logic [lfps_pkg::LED_IDX_W-1:0]       req_led_index,
   input  logic                                 csr_wr_en,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lfps_pkg::PAIR_W-1:0]          csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lfps_pkg::LED_IDX_W-1:0]       rsp_led_echo,
   output logic [lfps_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [lfps_pkg::STEP_W-1:0]          rsp_step_now,
   output logic [lfps_pkg::KIND_W-1:0]          rsp_kind_now,
   output logic                                 rsp_finished
);

   lfps_pkg::pairs_type                  pairs_ff;
   lfps_pkg::entry_type                  mem_ff [lfps_pkg::LED_COUNT];
   logic [lfps_pkg::LED_COUNT-1:0]       ent_valid_ff;
   lfps_pkg::entry_type                  rd_data_ff;
   logic                                 rd_valid_ff;
   logic [lfps_pkg::LED_IDX_W-1:0]       led_ff;

   lfps_pkg::entry_type                  new_entry_ff;
   logic [lfps_pkg::KIND_W-1:0]          new_kind_ff;
   logic                                 use_div_ff;
   logic [lfps_pkg::NUM_W-1:0]           div_num_ff;
   logic [lfps_pkg::REM_W-1:0]           div_rem_ff;
   logic [lfps_pkg::LEN_W-1:0]           div_den_ff;
   logic [lfps_pkg::DIV_CNT_W-1:0]       div_cnt_ff;

   logic                                 rsp_valid_ff;
   logic [lfps_pkg::LED_IDX_W-1:0]       rsp_led_ff;
   logic [lfps_pkg::LEVEL_W-1:0]         rsp_level_ff;
   logic [lfps_pkg::STEP_W-1:0]          rsp_step_ff;
   logic [lfps_pkg::KIND_W-1:0]          rsp_kind_ff;
   logic                                 rsp_done_ff;

   lfps_pkg::entry_type                  cur;
   lfps_pkg::entry_type                  nxt;
   logic [lfps_pkg::LEN_W-1:0]           len_cur;
   logic [lfps_pkg::LEN_W-1:0]           len_new;
   logic [lfps_pkg::KIND_W-1:0]          kind_new;
   logic [lfps_pkg::LEN_W-1:0]           base;
   logic [lfps_pkg::NUM_W-1:0]           numer;
   logic                                 need_div;
   logic [lfps_pkg::REM_W-1:0]           rem_sh;
   logic                                 rem_ge;
   logic [lfps_pkg::LEVEL_W-1:0]         level_out;
   logic                                 out_free;

   // Program registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff <= lfps_pkg::PAIR_RESET;
      end else if (csr_wr_en && (csr_index < lfps_pkg::CSR_IDX_W'(lfps_pkg::PAIR_COUNT))) begin
         pairs_ff[csr_index[lfps_pkg::PAIR_IDX_W-1:0]] <= csr_wr_data;
      end
   end

   // State memory: registered read on accept, write at the end of the request.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_data_ff <= mem_ff[req_led_index];
         led_ff     <= req_led_index;
      end
      if (cmd.write) begin
         mem_ff[led_ff] <= '{frame: new_entry_ff.frame, step: new_entry_ff.step,
                             done: new_entry_ff.done, level: level_out};
      end
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            rd_valid_ff <= ent_valid_ff[req_led_index];
         end
         if (cmd.write) begin
            ent_valid_ff[led_ff] <= 1'b1;
         end
      end
   end

   // Next LED state for one frame tick.
   always_comb begin
      cur     = rd_valid_ff ? rd_data_ff : '0;
      nxt     = cur;
      len_cur = lfps_pkg::step_len(pairs_ff, cur.step);
      if (!cur.done) begin
         if (cur.frame < len_cur) begin
            nxt.frame = cur.frame + lfps_pkg::LEN_W'(1);
         end else begin
            nxt.frame = '0;
            if (cur.step == lfps_pkg::LAST_STEP) begin
               nxt.done = 1'b1;
            end else begin
               nxt.step = cur.step + lfps_pkg::STEP_W'(1);
            end
         end
      end
      len_new  = lfps_pkg::step_len(pairs_ff, nxt.step);
      kind_new = lfps_pkg::step_kind(pairs_ff, nxt.step);
      need_div = !nxt.done && ((kind_new == lfps_pkg::KIND_IN) ||
                               (kind_new == lfps_pkg::KIND_OUT));
      base     = (kind_new == lfps_pkg::KIND_IN) ? nxt.frame : (len_new - nxt.frame);
      // base * 255 as base * 256 - base
      numer    = {base, lfps_pkg::LEN_W'(0)} - {lfps_pkg::LEN_W'(0), base};
   end

   // Restoring divider, one quotient bit a cycle; quotient shifts into div_num_ff.
   always_comb begin
      rem_sh = {div_rem_ff[lfps_pkg::REM_W-2:0], div_num_ff[lfps_pkg::NUM_W-1]};
      rem_ge = rem_sh >= {1'b0, div_den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         new_entry_ff <= nxt;
         new_kind_ff  <= kind_new;
         use_div_ff   <= need_div;
         div_num_ff   <= numer;
         div_rem_ff   <= '0;
         div_den_ff   <= len_new;
         div_cnt_ff   <= lfps_pkg::DIV_LAST;
      end else if (cmd.div_step) begin
         div_rem_ff <= rem_ge ? (rem_sh - {1'b0, div_den_ff}) : rem_sh;
         div_num_ff <= {div_num_ff[lfps_pkg::NUM_W-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff - lfps_pkg::DIV_CNT_W'(1);
      end
   end

   assign level_out = use_div_ff ? div_num_ff[lfps_pkg::LEVEL_W-1:0] : new_entry_ff.level;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_led_ff   <= led_ff;
         rsp_level_ff <= level_out;
         rsp_step_ff  <= new_entry_ff.step;
         rsp_kind_ff  <= new_kind_ff;
         rsp_done_ff  <= new_entry_ff.done;
      end
   end

   assign status.need_div = need_div;
   assign status.div_last = div_cnt_ff == '0;
   assign status.out_free = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_echo = rsp_led_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_step_now = rsp_step_ff;
   assign rsp_kind_now = rsp_kind_ff;
   assign rsp_finished = rsp_done_ff;

   `LFPS_ASSERT_IMP(a_quotient_fits, cmd.write && use_div_ff, div_num_ff[lfps_pkg::NUM_W-1:lfps_pkg::LEVEL_W] == '0)
   `LFPS_ASSERT_NEXT(a_entry_marked, cmd.write, ent_valid_ff[led_ff] && rsp_valid_ff)
   `LFPS_ASSERT_IMP(a_done_on_last, rsp_valid_ff && rsp_done_ff, rsp_step_ff == lfps_pkg::LAST_STEP)

endmodule

// ===== sv/lfps_ctrl.sv =====
// Controller: sequences read, update, divide and write-back for one request.
`include "led_fade_program_sequencer_core_assert.svh"

module lfps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lfps_pkg::status_type  status,
   output lfps_pkg::cmd_type     cmd
);

   lfps_pkg::state_type state_ff;
   lfps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         lfps_pkg::ST_IDLE: begin
            cmd.idle   = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = lfps_pkg::ST_EVAL;
            end
         end
         lfps_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.need_div ? lfps_pkg::ST_DIV : lfps_pkg::ST_WRITE;
         end
         lfps_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = lfps_pkg::ST_WRITE;
            end
         end
         lfps_pkg::ST_WRITE: begin
            // hold until the result register can take the request's result
            cmd.write = status.out_free;
            if (status.out_free) begin
               state_in = lfps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfps_pkg::ST_IDLE;
         end
      endcase
   end

   `LFPS_ASSERT_NEXT(a_eval_no_div, (state_ff == lfps_pkg::ST_EVAL) && !status.need_div, state_ff == lfps_pkg::ST_WRITE)
   `LFPS_ASSERT_NEXT(a_div_ends, (state_ff == lfps_pkg::ST_DIV) && status.div_last, state_ff == lfps_pkg::ST_WRITE)
   `LFPS_ASSERT_IMP(a_div_entry, state_ff == lfps_pkg::ST_DIV, ($past(state_ff) == lfps_pkg::ST_EVAL) || ($past(state_ff) == lfps_pkg::ST_DIV))

endmodule

// ===== sv/led_fade_program_sequencer_core.sv =====
// Top level of the LED fade program sequencer: controller plus datapath.
// Usage: each request on req_* is one frame tick for LED req_led_index. The
// block advances that LED's frame counter and program step and returns one
// result on rsp_*: the LED index, its level, its step, the step kind, done.
// Channels: valid/stall on both sides; a request is taken when req_valid is
// high and req_stall low, a result when rsp_valid is high and rsp_stall low.
// Flow: a request passes accept, update and write-back for wait and hold steps;
// fades add the restoring divider (base*255/length, base = frame for fade-in,
// length - frame for fade-out) before write-back. The result is registered in
// the cycle after write-back; the next request is taken while it still waits.
// Stall: with the result register full and rsp_stall high, write-back holds and
// req_stall stays high; the pending result never changes.
// Reset: synchronous, active high; all LEDs return to step 0, frame 0, level 0
// and the eight program words return to their power-up program. The user must
// write them via csr_wr_en/csr_index/csr_wr_data while idle; not enforced.
module led_fade_program_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lfps_pkg::LED_IDX_W-1:0]       req_led_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lfps_pkg::LED_IDX_W-1:0]       rsp_led_echo,
   output logic [lfps_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [lfps_pkg::STEP_W-1:0]          rsp_step_now,
   output logic [lfps_pkg::KIND_W-1:0]          rsp_kind_now,
   output logic                                 rsp_finished,
   input  logic                                 csr_wr_en,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lfps_pkg::PAIR_W-1:0]          csr_wr_data
);

   lfps_pkg::cmd_type    cmd;
   lfps_pkg::status_type status;

   // Take a request only while the controller is idle.
   assign req_stall = !cmd.idle;

   lfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   lfps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_led_index (req_led_index),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_echo  (rsp_led_echo),
      .rsp_level     (rsp_level),
      .rsp_step_now  (rsp_step_now),
      .rsp_kind_now  (rsp_kind_now),
      .rsp_finished  (rsp_finished)
   );

endmodule
